// File: src/cdca_pkg.sv
// Shared types and constants for the cyclic dominance cell update core.
package cdca_pkg;

    // Field widths fixed by the transaction format
    localparam int SPECIES_W  = 3;
    localparam int COORD_IN_W = 6;
    localparam int OPCODE_W   = 2;
    localparam int FRAC_W     = 8;
    localparam int DIR_W      = 3;
    localparam int MATCH_W    = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [SPECIES_W-1:0]  t_species;
    typedef logic [OPCODE_W-1:0]   t_opcode;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Opcodes (code 3 behaves as a read)
    localparam t_opcode OP_WRITE  = 2'd0;
    localparam t_opcode OP_UPDATE = 2'd1;
    localparam t_opcode OP_READ   = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx CFG_NUM_STATES   = 3'd0;
    localparam t_cfg_idx CFG_NEIGHBOR_CNT = 3'd1;
    localparam t_cfg_idx CFG_THRESH_MODE  = 3'd2;
    localparam t_cfg_idx CFG_COUNT_THRESH = 3'd3;
    localparam t_cfg_idx CFG_RATES        = 3'd4;
    localparam t_cfg_idx CFG_OFFSETS      = 3'd5;

    // Rate byte that accepts every attempt
    localparam logic [FRAC_W-1:0] RATE_ALWAYS = 8'hFF;

endpackage

// File: src/cyclic_dominance_ca_update_core.sv
// Top level: cyclic dominance cell update sequencer around the grid memory.
//
//   channel  direction  handshake                   payload
//   input    in         i_in_valid / o_in_ready     i_opcode, i_cell_x, i_cell_y,
//                                                   i_write_species, i_uniform_fraction,
//                                                   i_direction
//   output   out        o_out_valid / i_out_ready   o_cell_species, o_changed,
//                                                   o_match_count
//   config   in         i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// One transaction at a time. A write goes from idle straight to the done state; a read
// and an update attempt first read the cell, and an update attempt that reads neighbors
// then reads them one per cycle through the single grid read port and writes back.
// A finished result sits in the output register; the next transaction is taken
// meanwhile and only waits at its end if that register is still full.
// Reset (synchronous, active low) clears control and configuration, not the grid.
module cyclic_dominance_ca_update_core #(
    parameter int GRID_SIDE     = 64,
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  cdca_pkg::t_cfg_idx                   i_cfg_index,
    input  cdca_pkg::t_cfg_data                  i_cfg_data,
    // input transactions
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  cdca_pkg::t_opcode                    i_opcode,
    input  logic [cdca_pkg::COORD_IN_W-1:0]      i_cell_x,
    input  logic [cdca_pkg::COORD_IN_W-1:0]      i_cell_y,
    input  cdca_pkg::t_species                   i_write_species,
    input  logic [cdca_pkg::FRAC_W-1:0]          i_uniform_fraction,
    input  logic [cdca_pkg::DIR_W-1:0]           i_direction,
    // result transactions
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output cdca_pkg::t_species                   o_cell_species,
    output logic                                 o_changed,
    output logic [cdca_pkg::MATCH_W-1:0]         o_match_count
);
    import cdca_pkg::*;

    localparam int CW     = $clog2(GRID_SIDE);
    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int KW     = $clog2(MAX_NEIGHBORS);
    localparam int CNTW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int NIN    = 1 << COORD_IN_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CTR  = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_NBR  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Configuration registers
    logic [3:0]         r_cfg_ns;
    logic [3:0]         r_cfg_nc;
    logic               r_cfg_mode;
    logic [3:0]         r_cfg_thr;
    logic [63:0]        r_cfg_rates;
    logic [31:0]        r_cfg_offsets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ns      <= 4'd3;
            r_cfg_nc      <= 4'd4;
            r_cfg_mode    <= 1'b0;
            r_cfg_thr     <= 4'd1;
            r_cfg_rates   <= '1;
            r_cfg_offsets <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NUM_STATES:   r_cfg_ns      <= i_cfg_data[3:0];
                CFG_NEIGHBOR_CNT: r_cfg_nc      <= i_cfg_data[3:0];
                CFG_THRESH_MODE:  r_cfg_mode    <= i_cfg_data[0];
                CFG_COUNT_THRESH: r_cfg_thr     <= i_cfg_data[3:0];
                CFG_RATES:        r_cfg_rates   <= i_cfg_data;
                CFG_OFFSETS:      r_cfg_offsets <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Clamped ring size and neighbor count
    logic [3:0] w_ns;
    logic [3:0] w_nc;
    assign w_ns = (r_cfg_ns < 4'd2) ? 4'd2 : ((r_cfg_ns > 4'd8) ? 4'd8 : r_cfg_ns);
    assign w_nc = (r_cfg_nc < 4'd1) ? 4'd1 :
                  ((r_cfg_nc > 4'(MAX_NEIGHBORS)) ? 4'(MAX_NEIGHBORS) : r_cfg_nc);

    // Input coordinate reduction modulo the grid side (constant table)
    logic [CW-1:0] w_mod_tab [NIN];
    for (genvar g = 0; g < NIN; g++) begin : g_mod_tab
        assign w_mod_tab[g] = CW'(g % GRID_SIDE);
    end

    // Toroidal step of one coordinate by a 2-bit signed offset
    function automatic logic [CW-1:0] f_wrap(input logic [CW-1:0] c, input logic [1:0] d);
        logic [CW+1:0] t;
        logic [CW+1:0] side;
        logic [CW+1:0] res;
        side = (CW+2)'(GRID_SIDE);
        t    = {2'b00, c} + {{CW{d[1]}}, d};
        if (t[CW+1]) begin
            res = t + side;
        end else if (t >= side) begin
            res = t - side;
        end else begin
            res = t;
        end
        return res[CW-1:0];
    endfunction

    // Transaction registers
    logic [2:0]          r_state;
    t_opcode             r_op;
    logic [CW-1:0]       r_x;
    logic [CW-1:0]       r_y;
    logic [FRAC_W-1:0]   r_frac;
    logic [DIR_W-1:0]    r_dir;
    t_species            r_sp;
    t_species            r_dom;
    logic                r_accept;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_k_last;
    logic                r_pend;
    logic [CNTW-1:0]     r_cnt;
    t_species            r_res_species;
    logic                r_res_changed;
    logic [MATCH_W-1:0]  r_res_match;

    // Output register
    logic                r_out_valid;
    t_species            r_out_species;
    logic                r_out_changed;
    logic [MATCH_W-1:0]  r_out_match;

    // Memory port signals
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    t_species            w_wr_data;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    t_species            w_rd_data;

    // Addresses of the cell and of the current neighbor
    logic [AW-1:0]       w_ctr_addr;
    logic [AW-1:0]       w_nbr_addr;
    logic [3:0]          w_nib;
    logic [CW-1:0]       w_nx;
    logic [CW-1:0]       w_ny;
    logic [AW-1:0]       w_in_addr;

    assign w_in_addr  = AW'(w_mod_tab[i_cell_y]) * AW'(GRID_SIDE)
                        + AW'(w_mod_tab[i_cell_x]);
    assign w_ctr_addr = AW'(r_y) * AW'(GRID_SIDE) + AW'(r_x);
    assign w_nib      = r_cfg_offsets[4*r_k +: 4];
    assign w_nx       = f_wrap(r_x, w_nib[1:0]);
    assign w_ny       = f_wrap(r_y, w_nib[3:2]);
    assign w_nbr_addr = AW'(w_ny) * AW'(GRID_SIDE) + AW'(w_nx);

    // Evaluation of the cell species just read
    logic [FRAC_W-1:0]   w_rate;
    logic                w_accept;
    t_species            w_dom;
    logic                w_in_ring;
    assign w_rate    = r_cfg_rates[8*w_rd_data +: 8];
    assign w_accept  = (w_rate == RATE_ALWAYS) || (r_frac < w_rate);
    assign w_in_ring = {1'b0, w_rd_data} < w_ns;
    assign w_dom     = ({1'b0, w_rd_data} + 4'd1 == w_ns) ? '0 : w_rd_data + 3'd1;

    // Neighbor comparison and final decision
    logic                w_hit;
    logic [CNTW-1:0]     w_total;
    logic                w_turn;
    assign w_hit   = (w_rd_data == r_dom);
    assign w_total = r_cnt + CNTW'(w_hit);
    assign w_turn  = r_cfg_mode ? (r_accept && (MATCH_W'(w_total) >= r_cfg_thr)) : w_hit;

    logic w_in_fire;
    logic w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Memory port selection
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_in_addr;
        w_wr_data = i_write_species;
        if (w_in_fire && (i_opcode == OP_WRITE)) begin
            w_wr_en = 1'b1;
        end else if ((r_state == S_WB) && w_turn) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_ctr_addr;
            w_wr_data = r_dom;
        end
        w_rd_en   = (r_state == S_CTR) || (r_state == S_NBR);
        w_rd_addr = (r_state == S_NBR) ? w_nbr_addr : w_ctr_addr;
    end

    cdca_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= (i_opcode == OP_WRITE) ? S_DONE : S_CTR;
                    end
                end
                S_CTR: r_state <= S_EVAL;
                S_EVAL: begin
                    r_pend <= 1'b0;
                    if ((r_op != OP_UPDATE) || !w_in_ring) begin
                        r_state <= S_DONE;
                    end else if (r_cfg_mode) begin
                        r_state <= S_NBR;
                    end else if (w_accept && ({1'b0, r_dir} < w_nc)) begin
                        r_state <= S_NBR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_NBR: begin
                    r_pend <= 1'b1;
                    if (r_k == r_k_last) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Transaction payload path
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_op          <= i_opcode;
                    r_x           <= w_mod_tab[i_cell_x];
                    r_y           <= w_mod_tab[i_cell_y];
                    r_frac        <= i_uniform_fraction;
                    r_dir         <= i_direction;
                    r_res_species <= i_write_species;
                    r_res_changed <= 1'b0;
                    r_res_match   <= '0;
                end
            end
            S_EVAL: begin
                r_sp          <= w_rd_data;
                r_dom         <= w_dom;
                r_accept      <= w_accept;
                r_cnt         <= '0;
                r_res_species <= w_rd_data;
                r_res_changed <= 1'b0;
                r_res_match   <= '0;
                if (r_cfg_mode) begin
                    r_k      <= '0;
                    r_k_last <= KW'(w_nc - 4'd1);
                end else begin
                    r_k      <= KW'(r_dir);
                    r_k_last <= KW'(r_dir);
                end
            end
            S_NBR: begin
                if (r_pend) begin
                    r_cnt <= w_total;
                end
                if (r_k != r_k_last) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_WB: begin
                r_res_species <= w_turn ? r_dom : r_sp;
                r_res_changed <= w_turn;
                r_res_match   <= r_cfg_mode ? MATCH_W'(w_total) : '0;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_species <= r_res_species;
            r_out_changed <= r_res_changed;
            r_out_match   <= r_res_match;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cell_species = r_out_species;
    assign o_changed      = r_out_changed;
    assign o_match_count  = r_out_match;

endmodule

// File: src/cdca_grid_ram.sv
// Species grid memory: one write port, one registered read port.
module cdca_grid_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  cdca_pkg::t_species     i_wr_data,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output cdca_pkg::t_species     o_rd_data
);
    import cdca_pkg::*;

    t_species r_mem [DEPTH];
    t_species r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/sv/tb_cyclic_dominance_ca_update_core.sv
// Self-checking testbench for the cyclic dominance cell update core.
`timescale 1ns / 100ps

module tb_cyclic_dominance_ca_update_core;
    import cdca_pkg::*;

    localparam int GRID_SIDE     = 64;
    localparam int MAX_NEIGHBORS = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int PHASE_ITEMS   = 110;
    // Busy patch: columns and rows 60..63 and 0..7, straddling the wrap
    localparam int PATCH_BASE    = 60;
    localparam int PATCH_SPAN    = 12;

    // Code 3 decodes as a read
    localparam t_opcode OP_READ_ALT = 2'd3;

    localparam logic [63:0] RATES_ALWAYS = '1;
    localparam logic [31:0] OFFS_CROSS   = 32'h0000_C431;  // E, W, S, N, then self
    localparam logic [31:0] OFFS_MOORE   = 32'hFD75_C431;  // E, W, S, N, diagonals

    typedef struct packed {
        t_opcode     op;
        logic [5:0]  x;
        logic [5:0]  y;
        t_species    sp;
        logic [7:0]  frac;
        logic [2:0]  dir;
    } t_cell_op;

    typedef struct packed {
        t_species    species;
        logic        changed;
        logic [3:0]  match_cnt;
    } t_cell_report;

    typedef struct packed {
        logic [3:0]  states;
        logic [3:0]  nbrs;
        logic        mode;
        logic [3:0]  need;
        logic [63:0] rates;
        logic [31:0] offsets;
    } t_ca_settings;

    typedef struct packed {
        bit           is_reg;
        t_cell_op     op;
        bit           typed;
        t_cell_report want;
        t_cfg_idx     reg_idx;
        t_cfg_data    reg_val;
    } t_directed_row;

    // DUT connections, all driven to known values from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    t_cfg_idx           i_cfg_index = CFG_NUM_STATES;
    t_cfg_data          i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_opcode            i_opcode = OP_READ;
    logic [5:0]         i_cell_x = '0;
    logic [5:0]         i_cell_y = '0;
    t_species           i_write_species = '0;
    logic [7:0]         i_uniform_fraction = '0;
    logic [2:0]         i_direction = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_species           o_cell_species;
    logic               o_changed;
    logic [3:0]         o_match_count;

    // Shadow of the grid and of the register file
    t_species           grid_copy [GRID_SIDE*GRID_SIDE];
    bit                 cell_written [GRID_SIDE*GRID_SIDE];
    logic [3:0]         ring_states = 4'd3;
    logic [3:0]         nbr_count = 4'd4;
    logic               count_mode = 1'b0;
    logic [3:0]         need_count = 4'd1;
    logic [63:0]        species_rates = RATES_ALWAYS;
    logic [31:0]        nbr_offsets = '0;

    t_cell_report       cell_reports_due [$];
    t_directed_row      script [$];
    logic [11:0]        far_cells [$];
    int unsigned        burst_left = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        reports_checked = 0;
    int unsigned        ops_sent = 0;
    int unsigned        attempts = 0;
    int unsigned        counted_attempts = 0;
    int unsigned        turns = 0;
    int unsigned        cycle_count = 0;

    cyclic_dominance_ca_update_core #(
        .GRID_SIDE          (GRID_SIDE),
        .MAX_NEIGHBORS      (MAX_NEIGHBORS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_cell_x           (i_cell_x),
        .i_cell_y           (i_cell_y),
        .i_write_species    (i_write_species),
        .i_uniform_fraction (i_uniform_fraction),
        .i_direction        (i_direction),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_cell_species     (o_cell_species),
        .o_changed          (o_changed),
        .o_match_count      (o_match_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Torus wrap of one coordinate
    function automatic int unsigned wrap_coord(int unsigned c, int d);
        return (int'(c) + d + GRID_SIDE) % GRID_SIDE;
    endfunction

    function automatic int unsigned states_in_ring();
        return (ring_states < 2) ? 2 : ((ring_states > 8) ? 8 : int'(ring_states));
    endfunction

    function automatic t_species neighbor_species(int unsigned x, int unsigned y, int unsigned k);
        logic [3:0] nib;
        int dx, dy;
        nib = nbr_offsets[k*4 +: 4];
        dx = $signed(nib[1:0]);
        dy = $signed(nib[3:2]);
        return grid_copy[wrap_coord(y, dy) * GRID_SIDE + wrap_coord(x, dx)];
    endfunction

    // True when the cell and every cell any offset can reach hold written data
    function automatic bit window_ready(logic [5:0] x, logic [5:0] y);
        for (int dy = -2; dy <= 1; dy++)
            for (int dx = -2; dx <= 1; dx++)
                if (!cell_written[wrap_coord(y, dy) * GRID_SIDE + wrap_coord(x, dx)])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Applies one transaction to the shadow grid and returns the report it yields
    function automatic t_cell_report evolve_cell(t_cell_op it);
        t_cell_report r;
        int unsigned x, y, idx, ns, nc, sp, dom, rate, hits;
        bit accept, turn;
        x = it.x % GRID_SIDE;
        y = it.y % GRID_SIDE;
        idx = y * GRID_SIDE + x;
        hits = 0;
        turn = 1'b0;
        r = '0;
        case (it.op)
            OP_WRITE: begin
                grid_copy[idx] = it.sp;
                cell_written[idx] = 1'b1;
            end
            OP_UPDATE: begin
                ns = states_in_ring();
                nc = (nbr_count < 1) ? 1 : ((nbr_count > MAX_NEIGHBORS) ? MAX_NEIGHBORS : nbr_count);
                sp = grid_copy[idx];
                // species outside the ring never move
                if (sp < ns) begin
                    dom = (sp + 1) % ns;
                    rate = species_rates[sp*8 +: 8];
                    accept = (rate == RATE_ALWAYS) || (it.frac < rate);
                    if (count_mode) begin
                        for (int k = 0; k < nc; k++)
                            if (neighbor_species(x, y, k) == dom) hits++;
                        turn = accept && (hits >= need_count);
                    end else if (accept && it.dir < nc) begin
                        turn = (neighbor_species(x, y, it.dir) == dom);
                    end
                    if (turn) begin
                        grid_copy[idx] = t_species'(dom);
                        r.changed = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.species = grid_copy[idx];
        r.match_cnt = 4'(hits);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int exp_val);
        mismatch_count++;
        $display("[%0t] report %0d: %s is %0d, expected %0d",
                 $time, reports_checked, field, got, exp_val);
    endtask

    // Sender: bursts of back-to-back transactions with random gaps between
    task automatic send_cell_op(t_cell_op it, bit typed, t_cell_report want);
        t_cell_report pred;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid         <= 1'b1;
        i_opcode           <= it.op;
        i_cell_x           <= it.x;
        i_cell_y           <= it.y;
        i_write_species    <= it.sp;
        i_uniform_fraction <= it.frac;
        i_direction        <= it.dir;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = evolve_cell(it);
        cell_reports_due.push_back(typed ? want : pred);
        ops_sent++;
        if (it.op == OP_UPDATE) begin
            attempts++;
            if (count_mode) counted_attempts++;
            if (pred.changed) turns++;
        end
    endtask

    // Wait until every report is in and the core has gone quiet
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (cell_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(t_cfg_idx idx, t_cfg_data val);
        settle_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_NUM_STATES:   ring_states   = val[3:0];
            CFG_NEIGHBOR_CNT: nbr_count     = val[3:0];
            CFG_THRESH_MODE:  count_mode    = val[0];
            CFG_COUNT_THRESH: need_count    = val[3:0];
            CFG_RATES:        species_rates = val;
            CFG_OFFSETS:      nbr_offsets   = val[31:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(t_ca_settings s);
        program_reg(CFG_NUM_STATES,   t_cfg_data'(s.states));
        program_reg(CFG_NEIGHBOR_CNT, t_cfg_data'(s.nbrs));
        program_reg(CFG_THRESH_MODE,  t_cfg_data'(s.mode));
        program_reg(CFG_COUNT_THRESH, t_cfg_data'(s.need));
        program_reg(CFG_RATES,        s.rates);
        program_reg(CFG_OFFSETS,      t_cfg_data'(s.offsets));
    endtask

    function automatic logic [63:0] random_rates();
        logic [63:0] r;
        for (int b = 0; b < 8; b++)
            case ($urandom_range(0, 7))
                0, 1:    r[b*8 +: 8] = RATE_ALWAYS;
                2:       r[b*8 +: 8] = 8'h00;
                default: r[b*8 +: 8] = 8'($urandom);
            endcase
        return r;
    endfunction

    // Mostly sane ring sizes and thresholds, now and then out of range
    function automatic t_ca_settings random_settings();
        t_ca_settings s;
        s.states  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(2, 8));
        s.nbrs    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        s.mode    = 1'($urandom);
        s.need    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
        s.rates   = random_rates();
        s.offsets = $urandom;
        return s;
    endfunction

    // Coordinate inside the busy patch; update targets keep their window inside it
    function automatic logic [5:0] patch_coord(bit for_update);
        if (for_update)
            return 6'((PATCH_BASE + 2 + $urandom_range(0, PATCH_SPAN - 4)) % GRID_SIDE);
        return 6'((PATCH_BASE + $urandom_range(0, PATCH_SPAN - 1)) % GRID_SIDE);
    endfunction

    task automatic run_phase(t_ca_settings s, int unsigned n_items);
        t_cell_op it;
        t_cell_report none;
        int unsigned pick;
        logic [11:0] far;
        none = '0;
        apply_settings(s);
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            it.frac = 8'($urandom);
            it.dir  = 3'($urandom);
            it.sp   = 3'($urandom);
            it.x    = patch_coord(1'b1);
            it.y    = patch_coord(1'b1);
            if (pick < 55) begin
                it.op = OP_UPDATE;
            end else if (pick < 61) begin
                // anywhere on the grid when its window is loaded
                it.op = OP_UPDATE;
                far = 12'($urandom);
                if (window_ready(far[5:0], far[11:6])) begin
                    it.x = far[5:0];
                    it.y = far[11:6];
                end
            end else if (pick < 79) begin
                it.op = OP_WRITE;
                it.x  = patch_coord(1'b0);
                it.y  = patch_coord(1'b0);
                if ($urandom_range(0, 4) != 0)
                    it.sp = 3'($urandom_range(0, states_in_ring() - 1));
            end else if (pick < 86) begin
                it.op = OP_WRITE;
                it.x  = 6'($urandom);
                it.y  = 6'($urandom);
                far_cells.push_back({it.y, it.x});
            end else begin
                it.op = (pick < 93) ? OP_READ : OP_READ_ALT;
                it.x  = patch_coord(1'b0);
                it.y  = patch_coord(1'b0);
                if (pick >= 96 && far_cells.size() != 0) begin
                    far  = far_cells[$urandom_range(0, far_cells.size() - 1)];
                    it.x = far[5:0];
                    it.y = far[11:6];
                end
            end
            send_cell_op(it, 1'b0, none);
        end
    endtask

    function automatic t_directed_row row_op(t_opcode op, int x, int y, int sp, int frac,
                                             int dir, bit typed = 1'b0, int want_sp = 0);
        t_directed_row r;
        r = '0;
        r.op.op   = op;
        r.op.x    = 6'(x);
        r.op.y    = 6'(y);
        r.op.sp   = 3'(sp);
        r.op.frac = 8'(frac);
        r.op.dir  = 3'(dir);
        r.typed   = typed;
        r.want.species = 3'(want_sp);
        return r;
    endfunction

    function automatic t_directed_row row_reg(t_cfg_idx idx, t_cfg_data val);
        t_directed_row r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Receiver: ready follows a random 16-bit pattern, reloaded each period
    logic [15:0] stall_pattern = '1;
    int unsigned stall_step = 0;
    always @(posedge i_clk) begin
        if (stall_step == 15) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern <= '1;
                1:       stall_pattern <= 16'($urandom) & 16'($urandom);
                default: stall_pattern <= 16'($urandom) | 16'($urandom);
            endcase
        end
        stall_step  <= (stall_step + 1) % 16;
        i_out_ready <= stall_pattern[stall_step];
    end

    // Compare each report transaction with the oldest prediction
    always @(posedge i_clk) begin : check_cell_report
        t_cell_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cell_reports_due.size() == 0) begin
                report_mismatch("report with no transaction pending, species",
                                o_cell_species, -1);
            end else begin
                want = cell_reports_due.pop_front();
                if (o_cell_species !== want.species)
                    report_mismatch("cell_species", o_cell_species, want.species);
                if (o_changed !== want.changed)
                    report_mismatch("changed", o_changed, want.changed);
                if (o_match_count !== want.match_cnt)
                    report_mismatch("match_count", o_match_count, want.match_cnt);
            end
            reports_checked++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, cell_reports_due.size());
            $display("cyclic_dominance_ca_update_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_cell_op it;
        t_cell_report none;
        none = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: op, x, y, species, fraction, direction, typed, species out
        script.push_back(row_op(OP_WRITE,     0,  0, 1,   0, 0, 1'b1, 1));
        script.push_back(row_op(OP_WRITE,    63, 63, 7, 255, 7, 1'b1, 7));
        script.push_back(row_op(OP_READ,     63, 63, 0,   0, 0, 1'b1, 7));
        // species 7 is outside a ring of 3
        script.push_back(row_op(OP_UPDATE,   63, 63, 0, 255, 7, 1'b1, 7));
        // zero offsets point at the cell itself
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,   0, 0, 1'b1, 1));
        script.push_back(row_op(OP_READ_ALT,  0,  0, 5,   9, 3, 1'b1, 1));
        script.push_back(row_reg(CFG_OFFSETS, t_cfg_data'(OFFS_CROSS)));
        script.push_back(row_op(OP_WRITE,     1,  0, 2,   0, 0, 1'b1, 2));
        script.push_back(row_op(OP_WRITE,    63,  0, 0,   0, 0, 1'b1, 0));
        script.push_back(row_op(OP_WRITE,     0,  1, 2,   0, 0, 1'b1, 2));
        script.push_back(row_op(OP_WRITE,     0, 63, 2,   0, 0, 1'b1, 2));
        // direction past the neighbor count
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,   0, 5, 1'b1, 1));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0, 128, 0));
        script.push_back(row_reg(CFG_THRESH_MODE, 64'd1));
        script.push_back(row_reg(CFG_COUNT_THRESH, 64'd0));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0, 200, 0));
        // threshold above the neighbor count
        script.push_back(row_reg(CFG_COUNT_THRESH, 64'd9));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,   0, 0));
        // species 0 never accepted: match count still reported
        script.push_back(row_reg(CFG_RATES, 64'hFFFF_FFFF_FF80_4000));
        script.push_back(row_reg(CFG_COUNT_THRESH, 64'd1));
        script.push_back(row_op(OP_WRITE,    63,  0, 1,   0, 0, 1'b1, 1));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,   0, 0));
        // ring and neighbor count below range
        script.push_back(row_reg(CFG_NUM_STATES, 64'd0));
        script.push_back(row_reg(CFG_NEIGHBOR_CNT, 64'd0));
        script.push_back(row_reg(CFG_THRESH_MODE, 64'd0));
        script.push_back(row_op(OP_WRITE,     0,  0, 1,   0, 0, 1'b1, 1));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,   0, 0));
        script.push_back(row_op(OP_WRITE,     1,  0, 0,   0, 0, 1'b1, 0));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0,  63, 0));
        // ring and neighbor count above range, species 7 wraps to 0
        script.push_back(row_reg(CFG_NUM_STATES, 64'd15));
        script.push_back(row_reg(CFG_NEIGHBOR_CNT, 64'd15));
        script.push_back(row_reg(CFG_THRESH_MODE, 64'd1));
        script.push_back(row_op(OP_WRITE,     0,  0, 7,   0, 0, 1'b1, 7));
        script.push_back(row_op(OP_UPDATE,    0,  0, 0, 255, 0));

        foreach (script[i]) begin
            if (script[i].is_reg)
                program_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_cell_op(script[i].op, script[i].typed, script[i].want);
        end

        // Load the busy patch so every offset lands on written cells
        for (int py = 0; py < PATCH_SPAN; py++) begin
            for (int px = 0; px < PATCH_SPAN; px++) begin
                it.op   = OP_WRITE;
                it.x    = 6'((PATCH_BASE + px) % GRID_SIDE);
                it.y    = 6'((PATCH_BASE + py) % GRID_SIDE);
                it.sp   = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
                it.frac = 8'($urandom);
                it.dir  = 3'($urandom);
                send_cell_op(it, 1'b0, none);
            end
        end

        // Random phases: fixed settings first, extremes among them, then fully random settings
        run_phase('{4'd2, 4'd1, 1'b0, 4'd0, RATES_ALWAYS, 32'($urandom)}, PHASE_ITEMS);
        run_phase('{4'd8, 4'd8, 1'b1, 4'd8, random_rates(), OFFS_MOORE}, PHASE_ITEMS);
        run_phase('{4'd3, 4'd4, 1'b0, 4'd1, RATES_ALWAYS, OFFS_CROSS}, PHASE_ITEMS);
        run_phase('{4'd4, 4'd8, 1'b1, 4'd2, random_rates(), OFFS_MOORE}, PHASE_ITEMS);
        run_phase('{4'd0, 4'd0, 1'b1, 4'd0, 64'd0, 32'hFFFF_FFFF}, PHASE_ITEMS);
        run_phase('{4'd15, 4'd15, 1'b1, 4'd15, random_rates(), 32'($urandom)}, PHASE_ITEMS);
        run_phase(random_settings(), PHASE_ITEMS);
        run_phase(random_settings(), PHASE_ITEMS);

        settle_idle();
        $display("Summary: %0d transactions sent, %0d reports checked, %0d mismatches",
                 ops_sent, reports_checked, mismatch_count);
        $display("Summary: %0d update attempts, %0d in threshold mode, %0d turned a cell",
                 attempts, counted_attempts, turns);
        if (mismatch_count == 0) begin
            $display("cyclic_dominance_ca_update_core verification clean");
        end else begin
            $display("cyclic_dominance_ca_update_core verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/cdca_pkg.sv
src/cdca_grid_ram.sv
src/cyclic_dominance_ca_update_core.sv
tb/sv/tb_cyclic_dominance_ca_update_core.sv
